FILE: rtl/psscb_pkg.sv
// ----------------------------------------------------------------------------
// psscb_pkg
// Shared types, codes and command/status bundles of the pose source selector.
// ----------------------------------------------------------------------------
package psscb_pkg;

  localparam int VarW = 32;
  localparam int DevW = 16;

  // request kinds
  localparam logic [1:0] REQ_GNSS = 2'd0;
  localparam logic [1:0] REQ_NDT  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // source codes
  localparam logic [1:0] SRC_NDT   = 2'd0;
  localparam logic [1:0] SRC_GNSS  = 2'd1;
  localparam logic [1:0] SRC_BLEND = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_REPORT = 2'd0;
  localparam logic [1:0] KIND_FWD    = 2'd1;
  localparam logic [1:0] KIND_NDT    = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_YAW_DEV_MAX   = 3'd0;
  localparam logic [2:0] CFG_Z_DEV_MAX     = 3'd1;
  localparam logic [2:0] CFG_GNSS_XY_LOWER = 3'd2;
  localparam logic [2:0] CFG_GNSS_XY_UPPER = 3'd3;
  localparam logic [2:0] CFG_NDT_DEV_LOWER = 3'd4;
  localparam logic [2:0] CFG_NDT_DEV_UPPER = 3'd5;
  localparam logic [2:0] CFG_GNSS_TIMEOUT  = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_SQ_START, ST_SQ_WAIT, ST_GNSS_SEL, ST_EMIT_REP,
    ST_EMIT_FWD, ST_EMIT_PASS, ST_AX_SQ_START, ST_AX_SQ_WAIT, ST_AX_BOUND,
    ST_AX_MUL, ST_AX_DIV_START, ST_AX_DIV_WAIT, ST_AX_SUB, ST_AX_SQUARE,
    ST_AX_FLOOR, ST_AX_STORE, ST_AX_NEXT, ST_EMIT_BLEND
  } state_t;

  typedef enum logic [1:0] {MUL_NONE, MUL_PROD, MUL_SQUARE, MUL_FLOOR} mul_op_t;

  typedef enum logic [1:0] {OSEL_REPORT, OSEL_FWD, OSEL_PASS, OSEL_BLEND} out_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       tick;
    logic       sq_start;
    logic [1:0] sq_sel;
    logic       sq_store;
    logic       n_load;
    logic       gnss_update;
    logic       res_pass;
    logic       res_blend;
    logic       r_low;
    mul_op_t    mul_op;
    logic       div_start;
    logic       sub;
    logic       keep;
    logic       out_load;
    out_sel_t   out_sel;
    logic       out_last;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] src;
    logic       stale;
    logic       sq_done;
    logic       sq_busy;
    logic       div_done;
    logic       in_bounds;
    logic       eq_bounds;
    logic       out_free;
  } status_t;

endpackage

FILE: rtl/psscb_isqrt.sv
// ----------------------------------------------------------------------------
// psscb_isqrt
// Iterative floor square root of a 32-bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module psscb_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] operand,
  output logic        busy,
  output logic        done,
  output logic [15:0] root
);
  import psscb_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] v_r, v_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [19:0] t, trial;

  always_comb begin
    t        = {rem_r, v_r[31:30]};
    trial    = {2'b0, root_r, 2'b01};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = operand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      v_nxt = {v_r[29:0], 2'b00};
      if (t >= trial) begin
        rem_nxt  = 18'(t - trial);
        root_nxt = {root_r[14:0], 1'b1};
      end else begin
        rem_nxt  = t[17:0];
        root_nxt = {root_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

FILE: rtl/psscb_div.sv
// ----------------------------------------------------------------------------
// psscb_div
// Restoring unsigned divider, 32-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module psscb_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import psscb_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] d_r, d_nxt;
  logic [16:0] t;

  always_comb begin
    t        = {rem_r, q_r[31]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (t >= {1'b0, d_r}) begin
        rem_nxt = 16'(t - {1'b0, d_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = t[15:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/psscb_dp.sv
// ----------------------------------------------------------------------------
// psscb_dp
// Datapath: config registers, item registers, sqrt/divide units, multiplier,
// source decision, blend arithmetic and the result register.
// ----------------------------------------------------------------------------
module psscb_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  psscb_pkg::cmd_t      cmd,
  output psscb_pkg::status_t   status,
  input  logic [1:0]           in_tuser,
  input  logic [127:0]         in_tdata,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [127:0]         out_tdata,
  output logic [3:0]           out_tuser,
  output logic                 out_tlast
);
  import psscb_pkg::*;

  logic [15:0] yaw_max_r, z_max_r, gxy_lo_r, gxy_up_r, ndt_lo_r, ndt_up_r;
  logic [31:0] timeout_r;

  logic [1:0]  req_r;
  logic [31:0] vx_r, vy_r, vz_r, vyaw_r;
  logic [15:0] sx_r, sy_r, sz_r, syaw_r;
  logic [15:0] gx_r, gy_r, gz_r;
  logic [1:0]  src_r;
  logic [31:0] ticks_r;
  logic [15:0] n_r, mag_r;
  logic        big_r, neg_r;
  logic signed [33:0] mres_r;
  logic [31:0] keep_r;
  logic [31:0] rx_r, ry_r, rz_r;

  logic        out_valid_r;
  logic [1:0]  okind_r, osrc_r;
  logic        olast_r;
  logic [127:0] odata_r;

  logic [31:0] sq_operand, var_ax;
  logic [15:0] root, g;
  logic        sq_busy, sq_done, div_done;
  logic [31:0] quo;
  logic [16:0] sum_xy;
  logic [1:0]  src_new;
  logic signed [16:0] ma, mb, bd;
  logic [33:0] pm;
  logic [16:0] bd_mag;
  logic signed [33:0] qs, rr;
  logic [33:0] rmag;
  logic [31:0] sq_mag;

  always_comb begin
    case (cmd.sq_sel)
      2'd0:    sq_operand = vx_r;
      2'd1:    sq_operand = vy_r;
      2'd2:    sq_operand = vz_r;
      default: sq_operand = vyaw_r;
    endcase
    case (cmd.axis)
      2'd0:    begin var_ax = vx_r; g = gx_r; end
      2'd1:    begin var_ax = vy_r; g = gy_r; end
      default: begin var_ax = vz_r; g = gz_r; end
    endcase
  end

  psscb_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sq_start),
    .operand (sq_operand),
    .busy    (sq_busy),
    .done    (sq_done),
    .root    (root)
  );

  // divide operands: magnitudes, sign handled here
  assign pm     = mres_r[33] ? 34'(-mres_r) : 34'(mres_r);
  assign bd     = $signed({1'b0, gxy_up_r}) - $signed({1'b0, gxy_lo_r});
  assign bd_mag = bd[16] ? 17'(-bd) : 17'(bd);

  psscb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (pm[31:0]),
    .divisor  (bd_mag[15:0]),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    sum_xy = {1'b0, sx_r} + {1'b0, sy_r};
    if (syaw_r > yaw_max_r || sz_r > z_max_r) src_new = SRC_NDT;
    else if (sum_xy <= {gxy_lo_r, 1'b0})     src_new = SRC_GNSS;
    else if (sum_xy <= {gxy_up_r, 1'b0})     src_new = SRC_BLEND;
    else                                     src_new = SRC_NDT;
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_PROD: begin
        ma = $signed({1'b0, g}) - $signed({1'b0, gxy_lo_r});
        mb = $signed({1'b0, ndt_up_r}) - $signed({1'b0, ndt_lo_r});
      end
      MUL_SQUARE: begin
        ma = $signed({1'b0, mag_r});
        mb = $signed({1'b0, mag_r});
      end
      default: begin
        ma = $signed({1'b0, ndt_lo_r});
        mb = $signed({1'b0, ndt_lo_r});
      end
    endcase
    qs     = neg_r ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    rr     = $signed({18'd0, ndt_up_r}) - qs;
    rmag   = rr[33] ? 34'(-rr) : 34'(rr);
    sq_mag = mres_r[31:0];
  end

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_max_r <= 16'd13;
      z_max_r   <= 16'd26;
      gxy_lo_r  <= 16'd26;
      gxy_up_r  <= 16'd64;
      ndt_lo_r  <= 16'd38;
      ndt_up_r  <= 16'd77;
      timeout_r <= 32'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_YAW_DEV_MAX:   yaw_max_r <= cfg_data[15:0];
        CFG_Z_DEV_MAX:     z_max_r   <= cfg_data[15:0];
        CFG_GNSS_XY_LOWER: gxy_lo_r  <= cfg_data[15:0];
        CFG_GNSS_XY_UPPER: gxy_up_r  <= cfg_data[15:0];
        CFG_NDT_DEV_LOWER: ndt_lo_r  <= cfg_data[15:0];
        CFG_NDT_DEV_UPPER: ndt_up_r  <= cfg_data[15:0];
        CFG_GNSS_TIMEOUT:  timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r   <= SRC_NDT;
      ticks_r <= '0;
      gx_r    <= '0;
      gy_r    <= '0;
      gz_r    <= '0;
    end else if (cmd.gnss_update) begin
      src_r   <= src_new;
      ticks_r <= '0;
      gx_r    <= sx_r;
      gy_r    <= sy_r;
      gz_r    <= sz_r;
    end else if (cmd.tick && ticks_r != '1) begin
      ticks_r <= ticks_r + 32'd1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r  <= in_tuser;
      vx_r   <= in_tdata[31:0];
      vy_r   <= in_tdata[63:32];
      vz_r   <= in_tdata[95:64];
      vyaw_r <= in_tdata[127:96];
    end
    if (cmd.sq_store) begin
      case (cmd.sq_sel)
        2'd0:    sx_r   <= root;
        2'd1:    sy_r   <= root;
        2'd2:    sz_r   <= root;
        default: syaw_r <= root;
      endcase
    end
    if (cmd.n_load) n_r <= root;
    if (cmd.mul_op != MUL_NONE) mres_r <= ma * mb;
    if (cmd.div_start) neg_r <= mres_r[33] ^ bd[16];
    if (cmd.r_low) begin
      mag_r <= ndt_lo_r;
      big_r <= 1'b0;
    end else if (cmd.sub) begin
      mag_r <= rmag[15:0];
      big_r <= |rmag[33:16];
    end
    if (cmd.keep) keep_r <= big_r ? '1 : sq_mag;
    if (cmd.res_pass || cmd.res_blend) begin
      logic [31:0] v;
      v = cmd.res_pass ? var_ax : ((keep_r > sq_mag) ? keep_r : sq_mag);
      case (cmd.axis)
        2'd0:    rx_r <= v;
        2'd1:    ry_r <= v;
        default: rz_r <= v;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      osrc_r  <= src_r;
      olast_r <= cmd.out_last;
      unique case (cmd.out_sel)
        OSEL_REPORT: begin
          okind_r <= KIND_REPORT;
          odata_r <= '0;
        end
        OSEL_FWD: begin
          okind_r <= KIND_FWD;
          odata_r <= {vyaw_r, vz_r, vy_r, vx_r};
        end
        OSEL_PASS: begin
          okind_r <= KIND_NDT;
          odata_r <= {vyaw_r, vz_r, vy_r, vx_r};
        end
        default: begin
          okind_r <= KIND_NDT;
          odata_r <= {vyaw_r, rz_r, ry_r, rx_r};
        end
      endcase
    end
  end

  assign status.req_type  = req_r;
  assign status.src       = src_r;
  assign status.stale     = ticks_r > timeout_r;
  assign status.sq_done   = sq_done;
  assign status.sq_busy   = sq_busy;
  assign status.div_done  = div_done;
  assign status.in_bounds = (n_r >= ndt_lo_r) && (n_r <= ndt_up_r);
  assign status.eq_bounds = gxy_up_r == gxy_lo_r;
  assign status.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = {osrc_r, okind_r};
  assign out_tlast  = olast_r;

  a_gnss_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gnss_update |=> ticks_r == '0)
    else $error("tick count not cleared by gnss pose");

  a_res_one_way: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.res_pass && cmd.res_blend))
    else $error("pass and blend store together");

  a_no_sq_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sq_start |-> !sq_busy)
    else $error("sqrt started while busy");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

endmodule

FILE: rtl/psscb_ctrl.sv
// ----------------------------------------------------------------------------
// psscb_ctrl
// Controller: sequences sqrt, source decision, per-axis blend and emission.
// ----------------------------------------------------------------------------
module psscb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  psscb_pkg::status_t  status,
  output psscb_pkg::cmd_t     cmd
);
  import psscb_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    in_tready  = 1'b0;
    cmd        = '0;
    cmd.sq_sel = cnt_r;
    cmd.axis   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        cnt_nxt = '0;
        case (status.req_type)
          REQ_GNSS: state_nxt = ST_SQ_START;
          REQ_NDT: begin
            if (status.src == SRC_GNSS)                   state_nxt = ST_IDLE;
            else if (status.stale || status.src == SRC_NDT) state_nxt = ST_EMIT_PASS;
            else                                          state_nxt = ST_AX_SQ_START;
          end
          REQ_TICK: begin
            cmd.tick  = 1'b1;
            state_nxt = ST_IDLE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SQ_START: begin
        cmd.sq_start = 1'b1;
        state_nxt    = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (status.sq_done) begin
          cmd.sq_store = 1'b1;
          cnt_nxt      = cnt_r + 2'd1;
          state_nxt    = (cnt_r == 2'd3) ? ST_GNSS_SEL : ST_SQ_START;
        end
      end
      ST_GNSS_SEL: begin
        cmd.gnss_update = 1'b1;
        state_nxt       = ST_EMIT_REP;
      end
      ST_EMIT_REP: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_REPORT;
          cmd.out_last = status.src == SRC_NDT;
          state_nxt    = (status.src == SRC_NDT) ? ST_IDLE : ST_EMIT_FWD;
        end
      end
      ST_EMIT_FWD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_FWD;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_EMIT_PASS: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_PASS;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_AX_SQ_START: begin
        cmd.sq_start = 1'b1;
        state_nxt    = ST_AX_SQ_WAIT;
      end
      ST_AX_SQ_WAIT: begin
        if (status.sq_done) begin
          cmd.n_load = 1'b1;
          state_nxt  = ST_AX_BOUND;
        end
      end
      ST_AX_BOUND: begin
        if (!status.in_bounds) begin
          cmd.res_pass = 1'b1;
          state_nxt    = ST_AX_NEXT;
        end else if (status.eq_bounds) begin
          // equal gnss bounds: deviation is the lower ndt bound
          cmd.r_low = 1'b1;
          state_nxt = ST_AX_SQUARE;
        end else begin
          state_nxt = ST_AX_MUL;
        end
      end
      ST_AX_MUL: begin
        cmd.mul_op = MUL_PROD;
        state_nxt  = ST_AX_DIV_START;
      end
      ST_AX_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_AX_DIV_WAIT;
      end
      ST_AX_DIV_WAIT: begin
        if (status.div_done) state_nxt = ST_AX_SUB;
      end
      ST_AX_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = ST_AX_SQUARE;
      end
      ST_AX_SQUARE: begin
        cmd.mul_op = MUL_SQUARE;
        state_nxt  = ST_AX_FLOOR;
      end
      ST_AX_FLOOR: begin
        cmd.keep   = 1'b1;
        cmd.mul_op = MUL_FLOOR;
        state_nxt  = ST_AX_STORE;
      end
      ST_AX_STORE: begin
        cmd.res_blend = 1'b1;
        state_nxt     = ST_AX_NEXT;
      end
      ST_AX_NEXT: begin
        cnt_nxt   = cnt_r + 2'd1;
        state_nxt = (cnt_r == 2'd2) ? ST_EMIT_BLEND : ST_AX_SQ_START;
      end
      ST_EMIT_BLEND: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_BLEND;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/pose_source_select_covariance_blend.sv
// ----------------------------------------------------------------------------
// pose_source_select_covariance_blend
// Chooses between gnss, ndt and blended pose sources from covariance diagonals.
// ----------------------------------------------------------------------------
// gnss pose: four square roots, then one or two results
// ndt pose: blended with, per axis, a square root and (unless the axis passes through
//   or the gnss bounds are equal) a divide on the shared units; or passed through or dropped
// one item at a time (gnss pose, ndt pose or tick), next accepted once results are queued
// synchronous active-low reset restores register defaults, source ndt, counters zero
module pose_source_select_covariance_blend (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // var_x, var_y, var_z, var_yaw
  input  logic [1:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_var_x, out_var_y, out_var_z, out_var_yaw
  output logic [3:0]   out_tuser,  // out_kind, source
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import psscb_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  psscb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  psscb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
